[rtl/pac_pkg.sv]
// shared types and constants for the pouch alarm controller
`timescale 1ns / 1ps
`default_nettype none
package pac_pkg;
  localparam int UID_BYTES_DEF = 10;
  localparam int MAX_RES = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] OP_TICK = 4'd0;
  localparam logic [3:0] OP_LOCK = 4'd1;
  localparam logic [3:0] OP_UNLOCK = 4'd2;
  localparam logic [3:0] OP_ARM = 4'd3;
  localparam logic [3:0] OP_DISARM = 4'd4;
  localparam logic [3:0] OP_ALARM = 4'd5;
  localparam logic [3:0] OP_SILENCE = 4'd6;
  localparam logic [3:0] OP_LOCATE = 4'd7;
  localparam logic [3:0] OP_CONNECT = 4'd8;
  localparam logic [3:0] OP_DISCONNECT = 4'd9;
  localparam logic [3:0] OP_MOTION = 4'd10;
  localparam logic [3:0] OP_CARD = 4'd11;
  localparam logic [3:0] OP_CLEAR = 4'd12;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_EVENT = 3'd1;
  localparam logic [2:0] KIND_UPLOAD = 3'd2;
  localparam logic [2:0] KIND_ACK = 3'd3;
  localparam logic [2:0] KIND_STATUS = 3'd4;

  localparam logic [2:0] EV_LOCK_OK = 3'd0;
  localparam logic [2:0] EV_UNLOCK_OK = 3'd1;
  localparam logic [2:0] EV_ALARM = 3'd2;
  localparam logic [2:0] EV_TAMPER = 3'd3;
  localparam logic [2:0] EV_DEADMAN = 3'd4;
  localparam logic [2:0] EV_REJECT = 3'd5;
  localparam logic [2:0] UP_ALARM = 3'd0;
  localparam logic [2:0] UP_LOCATE = 3'd1;

  localparam logic [2:0] LED_OFF = 3'd0;
  localparam logic [2:0] LED_RED = 3'd1;
  localparam logic [2:0] LED_AMBER = 3'd2;
  localparam logic [2:0] LED_BLUE = 3'd3;
  localparam logic [2:0] LED_GREEN = 3'd4;

  localparam logic [2:0] CFG_THRESH = 3'd0;
  localparam logic [2:0] CFG_REST = 3'd1;
  localparam logic [2:0] CFG_GRACE = 3'd2;
  localparam logic [2:0] CFG_TEST = 3'd3;
  localparam logic [2:0] CFG_STROBE = 3'd4;
  localparam logic [2:0] CFG_STATUS = 3'd5;

  typedef struct packed {
    logic [3:0]  op;
    logic [15:0] accel_magnitude;
    logic [63:0] card_uid_low;
    logic [15:0] card_uid_high;
    logic [3:0]  card_uid_len;
  } in_word_t;

  typedef struct packed {
    logic [2:0] msg_kind;
    logic [2:0] msg_code;
    logic       is_locked;
    logic       is_armed;
    logic       is_alarming;
    logic       is_tampered;
    logic [2:0] led_colour;
    logic       last_of_run;
  } out_word_t;

  // one processed event: up to four messages and their count minus one
  typedef struct packed {
    logic [2:0]  count_m1;
    out_word_t [MAX_RES-1:0] msg;
  } batch_t;
endpackage
`default_nettype wire

[rtl/pac_front.sv]
// front: event state machine, one event a cycle, builds a batch of messages
`timescale 1ns / 1ps
`default_nettype none
module pac_front #(
  parameter int UID_BYTES = pac_pkg::UID_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [3:0]       cfg_index,
  input  wire logic [15:0]      cfg_data,
  input  wire logic             ev_valid,
  input  wire pac_pkg::in_word_t ev,
  output      pac_pkg::batch_t  batch
);
  import pac_pkg::*;

  localparam logic [3:0] UID_CAP = 4'(UID_BYTES);

  logic [15:0] thresh_r, rest_r, grace_ms_r, test_ms_r, status_ms_r;
  logic [9:0]  strobe_ms_r;

  logic locked_r, armed_r, alarm_r, tamper_r, link_r, grace_run_r, phase_r, enrolled_r;
  logic [15:0] grace_cnt_r, elapsed_r, silence_r, status_cnt_r;
  logic [9:0]  strobe_cnt_r;
  logic [63:0] own_lo_r;
  logic [15:0] own_hi_r;
  logic [3:0]  own_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= 16'd492; rest_r <= 16'd4096; grace_ms_r <= 16'd30000;
      test_ms_r <= 16'd10000; strobe_ms_r <= 10'd120; status_ms_r <= 16'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        {1'b0, CFG_THRESH}: thresh_r <= cfg_data;
        {1'b0, CFG_REST}:   rest_r <= cfg_data;
        {1'b0, CFG_GRACE}:  grace_ms_r <= cfg_data;
        {1'b0, CFG_TEST}:   test_ms_r <= cfg_data;
        {1'b0, CFG_STROBE}: strobe_ms_r <= cfg_data[9:0];
        {1'b0, CFG_STATUS}: status_ms_r <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  function automatic logic [79:0] uid_mask(input logic [3:0] n);
    logic [79:0] m;
    m = '0;
    for (int i = 0; i < 10; i++) if (4'(i) < n) m[i*8 +: 8] = 8'hff;
    uid_mask = m;
  endfunction

  // message stamped with the flags and led color as they stand
  function automatic out_word_t stamp(input logic [2:0] kind, input logic [2:0] code,
                                      input logic lk_i, input logic ar_i,
                                      input logic al_i, input logic tp_i,
                                      input logic ph_i);
    out_word_t w;
    logic [2:0] led;
    if (al_i) led = ph_i ? LED_RED : LED_OFF;
    else if (ar_i) led = LED_AMBER;
    else if (lk_i) led = LED_BLUE;
    else led = LED_GREEN;
    w.msg_kind = kind;
    w.msg_code = code;
    w.is_locked = lk_i;
    w.is_armed = ar_i;
    w.is_alarming = al_i;
    w.is_tampered = tp_i;
    w.led_colour = led;
    w.last_of_run = 1'b0;
    stamp = w;
  endfunction

  // next-state values, worked in program order
  logic lk, ar, al, tp, ln, gr, ph, en;
  logic [15:0] gc, el, sl, sc;
  logic [9:0] stc;
  logic [63:0] olo;
  logic [15:0] ohi;
  logic [3:0] olen;
  out_word_t [MAX_RES-1:0] msgs;
  logic [2:0] cnt;

  always_comb begin
    logic started, match;
    logic [15:0] d;
    logic [79:0] m, cu;
    logic [3:0] n, c;
    lk = locked_r; ar = armed_r; al = alarm_r; tp = tamper_r; ln = link_r;
    gr = grace_run_r; ph = phase_r; en = enrolled_r;
    gc = grace_cnt_r; el = elapsed_r; sl = silence_r; sc = status_cnt_r;
    stc = strobe_cnt_r; olo = own_lo_r; ohi = own_hi_r; olen = own_len_r;
    msgs = '0; cnt = 3'd0; started = 1'b0; match = 1'b0;
    d = '0; m = '0; n = '0; c = ev.op;
    cu = {ev.card_uid_high, ev.card_uid_low};

    // card decides which command runs
    if (ev.op == OP_CARD) begin
      if (!en) begin
        n = (ev.card_uid_len < UID_CAP) ? ev.card_uid_len : UID_CAP;
        m = uid_mask(n);
        olo = cu[63:0] & m[63:0]; ohi = cu[79:64] & m[79:64]; olen = n; en = 1'b1;
        c = OP_ARM;
      end else begin
        m = uid_mask(own_len_r);
        match = (ev.card_uid_len == own_len_r) && ((cu & m) == {own_hi_r, own_lo_r});
        c = match ? ((ar || lk || al) ? OP_DISARM : OP_ARM) : OP_CLEAR;
      end
    end
    if (ev.op == OP_TICK) begin
      sc = sat_inc(sc);
      if (al) el = sat_inc(el);
      if (gr) gc = sat_inc(gc);
      if (ar && !al && !ln && gr && gc >= grace_ms_r) begin
        gr = 1'b0; gc = '0;
        if (cnt < 3'd4) begin
          msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_DEADMAN, lk, ar, al, tp, ph);
          cnt = cnt + 3'd1;
        end
        al = 1'b1; el = '0; sl = '0; stc = '0; ph = !ph;
        if (cnt < 3'd4) begin
          msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_ALARM, lk, ar, al, tp, ph);
          cnt = cnt + 3'd1;
        end
        if (cnt < 3'd4) begin
          msgs[cnt[1:0]] = stamp(KIND_UPLOAD, UP_ALARM, lk, ar, al, tp, ph);
          cnt = cnt + 3'd1;
        end
        started = 1'b1;
      end
      if (al && !started) begin
        if (sl != 16'd0 && el >= sl) begin
          al = 1'b0; ph = 1'b0; sl = '0;
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_STATUS, 3'd0, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
          sc = '0;
        end else begin
          stc = (stc == 10'h3ff) ? stc : stc + 10'd1;
          if (stc >= strobe_ms_r) begin stc = '0; ph = !ph; end
        end
      end
      if (sc >= status_ms_r) begin
        if (cnt < 3'd4) begin
          msgs[cnt[1:0]] = stamp(KIND_STATUS, 3'd0, lk, ar, al, tp, ph);
          cnt = cnt + 3'd1;
        end
        sc = '0;
      end
    end else if (ev.op == OP_CARD && en && enrolled_r && !match) begin
      if (cnt < 3'd4) begin
        msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_REJECT, lk, ar, al, tp, ph);
        cnt = cnt + 3'd1;
      end
    end else if ((ev.op >= OP_LOCK && ev.op <= OP_LOCATE) || ev.op == OP_CARD) begin
      unique case (c)
        OP_LOCK: begin
          lk = 1'b1;
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_LOCK_OK, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
        end
        OP_UNLOCK: begin
          lk = 1'b0;
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_UNLOCK_OK, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
        end
        OP_ARM: begin lk = 1'b1; ar = 1'b1; gr = 1'b0; gc = '0; end
        OP_DISARM: begin lk = 1'b0; ar = 1'b0; tp = 1'b0; al = 1'b0; ph = 1'b0; end
        OP_ALARM: begin
          al = 1'b1; el = '0; sl = test_ms_r; stc = '0; ph = !ph;
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_ALARM, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_UPLOAD, UP_ALARM, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
        end
        OP_SILENCE: begin
          al = 1'b0; ph = 1'b0; sl = '0;
          if (ar && !ln) begin gr = 1'b1; gc = '0; end
        end
        default: begin
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_UPLOAD, UP_LOCATE, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
        end
      endcase
      if (cnt < 3'd4) begin
        msgs[cnt[1:0]] = stamp(KIND_ACK, 3'(c - 4'd1), lk, ar, al, tp, ph);
        cnt = cnt + 3'd1;
      end
      if (cnt < 3'd4) begin
        msgs[cnt[1:0]] = stamp(KIND_STATUS, 3'd0, lk, ar, al, tp, ph);
        cnt = cnt + 3'd1;
      end
      sc = '0;
    end else if (ev.op == OP_CONNECT) begin
      ln = 1'b1; gr = 1'b0; gc = '0;
    end else if (ev.op == OP_DISCONNECT) begin
      ln = 1'b0;
      if (ar) begin gr = 1'b1; gc = '0; end
    end else if (ev.op == OP_MOTION) begin
      if (ar) begin
        d = (ev.accel_magnitude >= rest_r) ? ev.accel_magnitude - rest_r
                                           : rest_r - ev.accel_magnitude;
        if (d > thresh_r && !tp) begin
          tp = 1'b1;
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_TAMPER, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
          al = 1'b1; el = '0; sl = '0; stc = '0; ph = !ph;
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_EVENT, EV_ALARM, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
          if (cnt < 3'd4) begin
            msgs[cnt[1:0]] = stamp(KIND_UPLOAD, UP_ALARM, lk, ar, al, tp, ph);
            cnt = cnt + 3'd1;
          end
        end
      end
    end else if (ev.op == OP_CLEAR) begin
      en = 1'b0; olen = '0; olo = '0; ohi = '0;
    end
    if (cnt == 3'd0) begin
      msgs[0] = stamp(KIND_NONE, 3'd0, lk, ar, al, tp, ph);
      cnt = 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0; armed_r <= 1'b0; alarm_r <= 1'b0; tamper_r <= 1'b0;
      link_r <= 1'b0; grace_run_r <= 1'b0; phase_r <= 1'b0; enrolled_r <= 1'b0;
      grace_cnt_r <= '0; elapsed_r <= '0; silence_r <= '0; status_cnt_r <= '0;
      strobe_cnt_r <= '0; own_lo_r <= '0; own_hi_r <= '0; own_len_r <= '0;
    end else if (ev_valid) begin
      locked_r <= lk; armed_r <= ar; alarm_r <= al; tamper_r <= tp;
      link_r <= ln; grace_run_r <= gr; phase_r <= ph; enrolled_r <= en;
      grace_cnt_r <= gc; elapsed_r <= el; silence_r <= sl; status_cnt_r <= sc;
      strobe_cnt_r <= stc; own_lo_r <= olo; own_hi_r <= ohi; own_len_r <= olen;
    end
  end

  always_comb begin
    batch.msg = msgs;
    batch.count_m1 = cnt - 3'd1;
    batch.msg[cnt[1:0] - 2'd1].last_of_run = 1'b1;
  end
endmodule
`default_nettype wire

[rtl/pac_back.sv]
// back: batch queue and message serializer with output register
`timescale 1ns / 1ps
`default_nettype none
module pac_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pac_pkg::batch_t   batch,
  output      logic              full,
  output      logic              out_valid,
  input  wire logic              out_stall,
  output      pac_pkg::out_word_t out_word
);
  import pac_pkg::*;

  batch_t q_r [QUEUE_DEPTH];
  logic wp_r, rp_r;
  logic [1:0] fill_r;
  logic [1:0] idx_r;
  logic valid_r;
  out_word_t word_r;
  logic load, pop;

  assign full = (fill_r == 2'(QUEUE_DEPTH));
  assign load = (fill_r != 2'd0) && (!valid_r || !out_stall);
  assign pop = load && (idx_r == q_r[rp_r].count_m1[1:0]);

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= batch;
    if (load) word_r <= q_r[rp_r].msg[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; fill_r <= '0; idx_r <= '0; valid_r <= 1'b0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      fill_r <= fill_r + 2'(push) - 2'(pop);
      if (load) idx_r <= pop ? 2'd0 : idx_r + 2'd1;
      if (load) valid_r <= 1'b1;
      else if (!out_stall) valid_r <= 1'b0;
    end
  end

  assign out_valid = valid_r;
  assign out_word = word_r;
endmodule
`default_nettype wire

[rtl/pouch_alarm_controller_core.sv]
// top level of the pouch alarm controller
// usage:
//  in_ channel: one event word per handshake (valid high, stall low)
//  out_ channel: messages, one word each, last_of_run marks the final
//    message of an event; every event yields one to four words
//  cfg_ port: write cfg_we with cfg_index 0..5 and cfg_data, only while idle
//  path: the front handles an event in the accept cycle and its batch is
//    written into the queue; the serializer then loads each word into the
//    output register, from which it is valid on out_
//  throughput: an event every cycle up to the two-batch queue, and one
//    word per cycle at the serializer while out_stall is low; an event
//    yields at most four words
//  reset: synchronous rst_n clears flags, timers, owner card and queue;
//    configuration returns to its defaults
//  receiver stall: out word holds; the queue fills and then in_stall rises
`timescale 1ns / 1ps
`default_nettype none
module pouch_alarm_controller_core #(
  parameter int UID_BYTES = pac_pkg::UID_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire pac_pkg::in_word_t  in_word,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      pac_pkg::out_word_t out_word
);
  import pac_pkg::*;

  batch_t batch;
  logic full, acc;

  // accept only while the queue has room
  assign in_stall = full;
  assign acc = in_valid && !full;

  pac_front #(.UID_BYTES(UID_BYTES)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .ev_valid(acc), .ev(in_word), .batch
  );

  pac_back u_back (
    .clk, .rst_n, .push(acc), .batch, .full,
    .out_valid, .out_stall, .out_word
  );
endmodule
`default_nettype wire

[bench/tb_pouch_alarm_controller_core.sv]
// self-checking testbench for the pouch alarm controller top level
`timescale 1ns / 1ps
module tb_pouch_alarm_controller_core;
  import pac_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;

  // idle percentages for the sender and the receiver, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  // messages still owed by the block, oldest first
  out_word_t owed_msgs[$];
  // messages of the event being predicted
  out_word_t run_msgs[$];

  always #4 clk = ~clk;

  pouch_alarm_controller_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  // ---------------------------------------------------------------------------
  // controller shadow: registers and state kept by the bench
  // ---------------------------------------------------------------------------
  logic [15:0] thresh_r, rest_r, grace_r, test_r, status_r;
  logic [9:0]  strobe_r;
  logic        locked, armed, alarming, tampered, link_up;
  logic        grace_on, strobe_ph, enrolled;
  logic [15:0] grace_cnt, alarm_age, silence_len, status_cnt;
  logic [9:0]  strobe_cnt;
  logic [63:0] owner_lo;
  logic [15:0] owner_hi;
  logic [3:0]  owner_len;

  function automatic logic [15:0] sat16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [79:0] uid_mask(input logic [3:0] n);
    logic [80:0] m;
    m = (81'd1 << (8 * n)) - 81'd1;
    return m[79:0];
  endfunction

  function automatic logic [2:0] led_now();
    if (alarming) return strobe_ph ? LED_RED : LED_OFF;
    if (armed) return LED_AMBER;
    if (locked) return LED_BLUE;
    return LED_GREEN;
  endfunction

  // stamps a message with the flags as they stand right now
  function automatic void post_msg(input logic [2:0] kind, input logic [2:0] code);
    out_word_t w;
    if (run_msgs.size() >= MAX_RES) return;
    w.msg_kind = kind;
    w.msg_code = code;
    w.is_locked = locked;
    w.is_armed = armed;
    w.is_alarming = alarming;
    w.is_tampered = tampered;
    w.led_colour = led_now();
    w.last_of_run = 1'b0;
    run_msgs.push_back(w);
  endfunction

  function automatic void push_status();
    post_msg(KIND_STATUS, 3'd0);
    status_cnt = '0;
  endfunction

  function automatic void stop_siren();
    alarming = 1'b0;
    strobe_ph = 1'b0;
  endfunction

  function automatic void raise_alarm(input logic [15:0] silence);
    alarming = 1'b1;
    alarm_age = '0;
    silence_len = silence;
    strobe_cnt = '0;
    strobe_ph = ~strobe_ph;
    post_msg(KIND_EVENT, EV_ALARM);
    post_msg(KIND_UPLOAD, UP_ALARM);
  endfunction

  function automatic void apply_command(input logic [3:0] c);
    case (c)
      OP_LOCK: begin
        locked = 1'b1;
        post_msg(KIND_EVENT, EV_LOCK_OK);
      end
      OP_UNLOCK: begin
        locked = 1'b0;
        post_msg(KIND_EVENT, EV_UNLOCK_OK);
      end
      OP_ARM: begin
        locked = 1'b1;
        armed = 1'b1;
        grace_on = 1'b0;
        grace_cnt = '0;
      end
      OP_DISARM: begin
        locked = 1'b0;
        armed = 1'b0;
        tampered = 1'b0;
        if (alarming) stop_siren();
      end
      OP_ALARM: raise_alarm(test_r);
      OP_SILENCE: begin
        stop_siren();
        silence_len = '0;
        if (armed && !link_up) begin
          grace_on = 1'b1;
          grace_cnt = '0;
        end
      end
      default: post_msg(KIND_UPLOAD, UP_LOCATE);
    endcase
    post_msg(KIND_ACK, 3'(c - 4'd1));
    push_status();
  endfunction

  function automatic void apply_tick();
    logic fresh;
    fresh = 1'b0;
    status_cnt = sat16(status_cnt);
    if (alarming) alarm_age = sat16(alarm_age);
    if (grace_on) grace_cnt = sat16(grace_cnt);
    // dead-man: link lost while armed for the grace time
    if (armed && !alarming && !link_up && grace_on && grace_cnt >= grace_r) begin
      grace_on = 1'b0;
      grace_cnt = '0;
      post_msg(KIND_EVENT, EV_DEADMAN);
      raise_alarm(16'd0);
      fresh = 1'b1;
    end
    // siren service, not on the tick that started it
    if (alarming && !fresh) begin
      if (silence_len != 0 && alarm_age >= silence_len) begin
        stop_siren();
        silence_len = '0;
        push_status();
      end else begin
        strobe_cnt = (strobe_cnt == 10'h3FF) ? strobe_cnt : strobe_cnt + 10'd1;
        if (strobe_cnt >= strobe_r) begin
          strobe_cnt = '0;
          strobe_ph = ~strobe_ph;
        end
      end
    end
    if (status_cnt >= status_r) push_status();
  endfunction

  function automatic void apply_card(input in_word_t w);
    logic [79:0] m;
    logic [3:0]  n;
    if (!enrolled) begin
      // enrollment keeps at most ten bytes
      n = (w.card_uid_len > 4'd10) ? 4'd10 : w.card_uid_len;
      m = uid_mask(n);
      owner_lo = w.card_uid_low & m[63:0];
      owner_hi = w.card_uid_high & m[79:64];
      owner_len = n;
      enrolled = 1'b1;
      apply_command(OP_ARM);
      return;
    end
    m = uid_mask(owner_len);
    if (w.card_uid_len == owner_len && (w.card_uid_low & m[63:0]) == owner_lo &&
        (w.card_uid_high & m[79:64]) == owner_hi) begin
      if (armed || locked || alarming) apply_command(OP_DISARM);
      else apply_command(OP_ARM);
    end else begin
      post_msg(KIND_EVENT, EV_REJECT);
    end
  endfunction

  // works out the messages of one accepted event and queues them
  function automatic void predict_event(input in_word_t w);
    logic [15:0] dev;
    out_word_t   tail;
    run_msgs.delete();
    case (w.op)
      OP_TICK: apply_tick();
      OP_LOCK, OP_UNLOCK, OP_ARM, OP_DISARM, OP_ALARM, OP_SILENCE, OP_LOCATE:
        apply_command(w.op);
      OP_CONNECT: begin
        link_up = 1'b1;
        grace_on = 1'b0;
        grace_cnt = '0;
      end
      OP_DISCONNECT: begin
        link_up = 1'b0;
        if (armed) begin
          grace_on = 1'b1;
          grace_cnt = '0;
        end
      end
      OP_MOTION: begin
        if (armed) begin
          dev = (w.accel_magnitude >= rest_r) ? w.accel_magnitude - rest_r
                                              : rest_r - w.accel_magnitude;
          if (dev > thresh_r && !tampered) begin
            tampered = 1'b1;
            post_msg(KIND_EVENT, EV_TAMPER);
            raise_alarm(16'd0);
          end
        end
      end
      OP_CARD: apply_card(w);
      OP_CLEAR: begin
        enrolled = 1'b0;
        owner_len = '0;
        owner_lo = '0;
        owner_hi = '0;
      end
      default: ;
    endcase
    if (run_msgs.size() == 0) post_msg(KIND_NONE, 3'd0);
    tail = run_msgs.pop_back();
    tail.last_of_run = 1'b1;
    run_msgs.push_back(tail);
    foreach (run_msgs[i]) owed_msgs.push_back(run_msgs[i]);
  endfunction

  function automatic void shadow_reset();
    thresh_r = 16'd492;
    rest_r = 16'd4096;
    grace_r = 16'd30000;
    test_r = 16'd10000;
    strobe_r = 10'd120;
    status_r = 16'd10000;
    {locked, armed, alarming, tampered, link_up, grace_on, strobe_ph, enrolled} = '0;
    {grace_cnt, alarm_age, silence_len, status_cnt} = '0;
    strobe_cnt = '0;
    owner_lo = '0;
    owner_hi = '0;
    owner_len = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one event word; leaves valid high so back-to-back words need no gap
  task automatic send_word(input in_word_t w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_event(w);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // waits until every owed message is back and the block has settled
  task automatic drain();
    release_input();
    while (owed_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      4'(CFG_THRESH): thresh_r = value;
      4'(CFG_REST):   rest_r = value;
      4'(CFG_GRACE):  grace_r = value;
      4'(CFG_TEST):   test_r = value;
      4'(CFG_STROBE): strobe_r = value[9:0];
      4'(CFG_STATUS): status_r = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [15:0] th, input logic [15:0] rs,
                           input logic [15:0] gr, input logic [15:0] ts,
                           input logic [15:0] sb, input logic [15:0] st);
    write_reg(4'(CFG_THRESH), th);
    write_reg(4'(CFG_REST), rs);
    write_reg(4'(CFG_GRACE), gr);
    write_reg(4'(CFG_TEST), ts);
    write_reg(4'(CFG_STROBE), sb);
    write_reg(4'(CFG_STATUS), st);
  endtask

  function automatic in_word_t make_word(input logic [3:0] op);
    in_word_t w;
    w.op = op;
    w.accel_magnitude = 16'($urandom);
    w.card_uid_low = {$urandom, $urandom};
    w.card_uid_high = 16'($urandom);
    w.card_uid_len = 4'($urandom);
    return w;
  endfunction

  function automatic in_word_t make_card(input logic [63:0] lo, input logic [15:0] hi,
                                         input logic [3:0] len);
    in_word_t w;
    w = make_word(OP_CARD);
    w.card_uid_low = lo;
    w.card_uid_high = hi;
    w.card_uid_len = len;
    return w;
  endfunction

  function automatic in_word_t make_motion(input logic [15:0] mag);
    in_word_t w;
    w = make_word(OP_MOTION);
    w.accel_magnitude = mag;
    return w;
  endfunction

  // random event biased toward ticks, owner cards and near-threshold motion
  function automatic in_word_t make_random_word();
    in_word_t    w;
    int unsigned r;
    int          mag;
    logic [79:0] m;
    r = $urandom_range(99);
    if (r < 35) begin
      w = make_word(OP_TICK);
    end else if (r < 47) begin
      w = make_word(OP_MOTION);
      if ($urandom_range(3) != 0) begin
        mag = int'(rest_r) + $urandom_range(2 * thresh_r + 2) - int'(thresh_r) - 1;
        if (mag < 0) mag = 0;
        if (mag > 65535) mag = 65535;
        w.accel_magnitude = 16'(mag);
      end
    end else if (r < 60) begin
      w = make_word(OP_CARD);
      if (enrolled && $urandom_range(9) < 7) begin
        // owner card, bytes past its length left random
        m = uid_mask(owner_len);
        w.card_uid_low = owner_lo | (w.card_uid_low & ~m[63:0]);
        w.card_uid_high = owner_hi | (w.card_uid_high & ~m[79:64]);
        w.card_uid_len = owner_len;
      end
    end else if (r < 68) begin
      w = make_word($urandom_range(1) ? OP_CONNECT : OP_DISCONNECT);
    end else begin
      w = make_word(4'($urandom_range(15, 1)));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // every op at least once with the reset configuration, plus card and motion corners
  task automatic test_directed_ops();
    send_word(make_word(OP_TICK));
    send_word(make_word(OP_LOCK));
    send_word(make_word(OP_UNLOCK));
    send_word(make_word(OP_LOCATE));
    send_word(make_motion(16'hFFFF));                // ignored while disarmed
    send_word(make_word(OP_ARM));
    send_word(make_word(OP_CONNECT));
    send_word(make_motion(16'd4096 + 16'd492));      // exactly at threshold
    send_word(make_motion(16'h0000));                // far below rest: tamper
    send_word(make_motion(16'hFFFF));                // already tampered
    send_word(make_word(OP_TICK));
    send_word(make_word(OP_SILENCE));
    send_word(make_word(OP_ALARM));
    send_word(make_word(OP_DISARM));
    // card of zero bytes enrolls and matches any other zero-length card
    send_word(make_card(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 4'd0));
    send_word(make_card(64'h0, 16'h0, 4'd0));
    send_word(make_word(OP_CLEAR));
    // longer than ten bytes: enrolled as ten, later matches only with len 10
    send_word(make_card(64'hA5A5_5A5A_0123_4567, 16'hBEEF, 4'd15));
    send_word(make_card(64'hA5A5_5A5A_0123_4567, 16'hBEEF, 4'd10));
    send_word(make_card(64'hA5A5_5A5A_0123_4567, 16'hBEEF, 4'd15));
    send_word(make_card(64'hA5A5_5A5A_0123_4567, 16'hBEEF, 4'd15));
    send_word(make_word(OP_DISCONNECT));
    send_word(make_word(4'd13));
    send_word(make_word(4'd14));
    send_word(make_word(4'd15));
    drain();
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned idle,
                            input int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n_items) send_word(make_random_word());
    drain();
  endtask

  // short timers so dead-man, auto-silence, strobe and status all fire
  task automatic test_short_timers();
    write_all(16'd100, 16'd4096, 16'd5, 16'd20, 16'd3, 16'd25);
    run_random(31, 0, 0);
  endtask

  // lowest legal settings: status every tick, grace of one tick
  task automatic test_low_extremes();
    write_all(16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1);
    run_random(31, 49, 0);
  endtask

  // highest settings: nothing trips, alarms never auto-silence
  task automatic test_high_extremes();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1023, 16'hFFFF);
    run_random(31, 0, 49);
  endtask

  // zero timers, a strobe write wider than the register, an unused index
  task automatic test_zero_timers();
    write_all(16'd300, 16'd2048, 16'd0, 16'd0, 16'hFFFF, 16'd0);
    write_reg(4'd9, 16'h1234);
    write_reg(4'(CFG_STROBE), 16'd0);
    run_random(31, 18, 18);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stall, word check against the oldest owed message
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_msgs.size() == 0) begin
        $error("unexpected word %h", out_word);
        mismatches++;
      end else begin
        want = owed_msgs.pop_front();
        if (out_word.msg_kind !== want.msg_kind) begin
          $error("msg_kind expected %0d got %0d", want.msg_kind, out_word.msg_kind);
          mismatches++;
        end
        if (out_word.msg_code !== want.msg_code) begin
          $error("msg_code expected %0d got %0d", want.msg_code, out_word.msg_code);
          mismatches++;
        end
        if (out_word.is_locked !== want.is_locked) begin
          $error("is_locked expected %0d got %0d", want.is_locked, out_word.is_locked);
          mismatches++;
        end
        if (out_word.is_armed !== want.is_armed) begin
          $error("is_armed expected %0d got %0d", want.is_armed, out_word.is_armed);
          mismatches++;
        end
        if (out_word.is_alarming !== want.is_alarming) begin
          $error("is_alarming expected %0d got %0d", want.is_alarming,
                 out_word.is_alarming);
          mismatches++;
        end
        if (out_word.is_tampered !== want.is_tampered) begin
          $error("is_tampered expected %0d got %0d", want.is_tampered,
                 out_word.is_tampered);
          mismatches++;
        end
        if (out_word.led_colour !== want.led_colour) begin
          $error("led_colour expected %0d got %0d", want.led_colour,
                 out_word.led_colour);
          mismatches++;
        end
        if (out_word.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0d got %0d", want.last_of_run,
                 out_word.last_of_run);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[pouch_alarm_controller_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    shadow_reset();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_short_timers();
    test_low_extremes();
    test_high_extremes();
    test_zero_timers();
    if (mismatches == 0) begin
      $display("[pouch_alarm_controller_core] OK");
    end else begin
      $display("[pouch_alarm_controller_core] ERROR");
    end
    $finish;
  end
endmodule

[pouch_alarm_controller_core.f]
rtl/pac_pkg.sv
rtl/pac_front.sv
rtl/pac_back.sv
rtl/pouch_alarm_controller_core.sv
bench/tb_pouch_alarm_controller_core.sv
